FILE: src/bmi_pkg.sv
// Shared types and constants for the binary modular inverse block.
// Depends on nothing; every other file of the block imports it.
package bmi_pkg;

   // Width of the operand, modulus and inverse fields on the channels.
   localparam int DATA_W = 64;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Commands from the controller to the datapath, one per cycle.
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_HALVE_U,
      CMD_HALVE_V,
      CMD_SUB_U,
      CMD_SUB_V,
      CMD_DONE_OK,
      CMD_DONE_ERR
   } cmd_type;

   // Flags that the datapath reports about its working registers.
   typedef struct packed {
      logic mod_even;
      logic u_even;
      logic v_even;
      logic v_one;
      logic u_gt_v;
      logic u_eq_v;
   } status_type;

endpackage

FILE: src/bmi_channels.sv
// Valid/ready channel interfaces for the request and response transactions.
// Depends on bmi_pkg for the field widths.
interface bmi_req_if;
   import bmi_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] operand;
   logic [DATA_W-1:0] modulus;

   modport source (output valid, output operand, output modulus, input ready);
   modport sink (input valid, input operand, input modulus, output ready);
endinterface

interface bmi_rsp_if;
   import bmi_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] inverse;
   logic              status;

   modport source (output valid, output inverse, output status, input ready);
   modport sink (input valid, input inverse, input status, output ready);
endinterface

FILE: src/bmi_ctrl.sv
// Controller of the binary modular inverse: picks one datapath step per cycle.
// Depends on bmi_pkg for the state, command and status types.
module bmi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   input  bmi_pkg::status_type status,
   output bmi_pkg::cmd_type    cmd
);
   import bmi_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;
   logic      finish;
   logic      done;

   // The response register may be written when empty or being emptied now.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // The item ends on an even modulus, when v reaches one, or when u meets v.
   assign finish = status.mod_even ||
                   (!status.u_even && !status.v_even &&
                    (status.v_one || status.u_eq_v));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (finish && slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd = CMD_LOAD;
            end
         end
         ST_RUN: begin
            if (status.mod_even) begin
               cmd = slot_free ? CMD_DONE_ERR : CMD_NONE;
            end else if (status.u_even) begin
               cmd = CMD_HALVE_U;
            end else if (status.v_even) begin
               cmd = CMD_HALVE_V;
            end else if (status.v_one) begin
               cmd = slot_free ? CMD_DONE_OK : CMD_NONE;
            end else if (status.u_gt_v) begin
               cmd = CMD_SUB_U;
            end else if (status.u_eq_v) begin
               cmd = slot_free ? CMD_DONE_ERR : CMD_NONE;
            end else begin
               cmd = CMD_SUB_V;
            end
         end
         default: begin
            cmd = CMD_NONE;
         end
      endcase
   end

   assign done         = (cmd == CMD_DONE_OK) || (cmd == CMD_DONE_ERR);
   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: src/bmi_datapath.sv
// Datapath of the binary modular inverse: working values, coefficients and
// the response register. Depends on bmi_pkg for the command and status types.
module bmi_datapath #(
   parameter int WIDTH = 64
) (
   input  logic                       clock,
   input  bmi_pkg::cmd_type           cmd,
   input  logic [bmi_pkg::DATA_W-1:0] operand,
   input  logic [bmi_pkg::DATA_W-1:0] modulus,
   output bmi_pkg::status_type        status,
   output logic [bmi_pkg::DATA_W-1:0] inverse,
   output logic                       rsp_status
);
   import bmi_pkg::*;

   logic [WIDTH:0]    u_ff, u_in;
   logic [WIDTH-1:0]  v_ff, v_in;
   logic [WIDTH-1:0]  x_ff, x_in;
   logic [WIDTH-1:0]  d_ff, d_in;
   logic [WIDTH-1:0]  m_ff, m_in;
   logic [DATA_W-1:0] inverse_ff, inverse_in;
   logic              status_ff, status_in;

   logic [WIDTH-1:0]  load_a;
   logic [WIDTH-1:0]  load_m;
   logic [WIDTH:0]    load_u;
   logic [WIDTH:0]    u_diff;
   logic [WIDTH-1:0]  v_diff;
   logic [WIDTH:0]    coef_sum;
   logic [WIDTH+1:0]  coef_red;
   logic [WIDTH-1:0]  coef_add;
   logic [WIDTH-1:0]  half_src;
   logic [WIDTH-1:0]  coef_half;

   assign load_a = operand[WIDTH-1:0];
   assign load_m = modulus[WIDTH-1:0];
   // An even operand is made odd by adding the modulus; u keeps the carry.
   assign load_u = load_a[0] ? {1'b0, load_a} : ({1'b0, load_a} + {1'b0, load_m});

   assign u_diff = u_ff - {1'b0, v_ff};
   assign v_diff = v_ff - u_ff[WIDTH-1:0];

   // Modular sum of the coefficients; it is the same for both subtract steps.
   assign coef_sum = {1'b0, d_ff} + {1'b0, x_ff};
   assign coef_red = {1'b0, coef_sum} - {2'b00, m_ff};
   assign coef_add = coef_red[WIDTH+1] ? coef_sum[WIDTH-1:0] : coef_red[WIDTH-1:0];

   // Modular halving: an odd value takes the modulus along before the shift.
   assign half_src  = (cmd == CMD_HALVE_U) ? d_ff : x_ff;
   assign coef_half = half_src[0] ? ((half_src >> 1) + (m_ff >> 1) + WIDTH'(1))
                                  : (half_src >> 1);

   always_comb begin
      u_in       = u_ff;
      v_in       = v_ff;
      x_in       = x_ff;
      d_in       = d_ff;
      m_in       = m_ff;
      inverse_in = inverse_ff;
      status_in  = status_ff;
      case (cmd)
         CMD_LOAD: begin
            u_in = load_u;
            v_in = load_m;
            x_in = '0;
            d_in = load_m - WIDTH'(1);
            m_in = load_m;
         end
         CMD_HALVE_U: begin
            u_in = u_ff >> 1;
            d_in = coef_half;
         end
         CMD_HALVE_V: begin
            v_in = v_ff >> 1;
            x_in = coef_half;
         end
         CMD_SUB_U: begin
            u_in = u_diff;
            d_in = coef_add;
         end
         CMD_SUB_V: begin
            v_in = v_diff;
            x_in = coef_add;
         end
         CMD_DONE_OK: begin
            inverse_in = (m_ff == WIDTH'(1)) ? '0 : DATA_W'(x_ff);
            status_in  = 1'b0;
         end
         CMD_DONE_ERR: begin
            inverse_in = '0;
            status_in  = 1'b1;
         end
         default: begin
            u_in = u_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      u_ff       <= u_in;
      v_ff       <= v_in;
      x_ff       <= x_in;
      d_ff       <= d_in;
      m_ff       <= m_in;
      inverse_ff <= inverse_in;
      status_ff  <= status_in;
   end

   assign status.mod_even = !m_ff[0];
   assign status.u_even   = !u_ff[0];
   assign status.v_even   = !v_ff[0];
   assign status.v_one    = (v_ff == WIDTH'(1));
   assign status.u_gt_v   = (u_ff > {1'b0, v_ff});
   assign status.u_eq_v   = (u_ff == {1'b0, v_ff});

   assign inverse    = inverse_ff;
   assign rsp_status = status_ff;

endmodule

FILE: src/binary_modular_inverse.sv
// Top level of the binary modular inverse block.
// Depends on bmi_pkg, bmi_channels, bmi_ctrl and bmi_datapath.
//
//   Channel    Direction  Payload                          Handshake
//   req_chan   in         operand[63:0], modulus[63:0]     valid / ready
//   rsp_chan   out        inverse[63:0], status            valid / ready
//
// Each request transaction is first loaded, then takes one subtract or halve
// step per cycle of the binary extended Euclid loop, then writes the response
// register; the number of steps depends on the data. The reset is synchronous
// and clears only the controller state and the response valid flag. A stalled
// response holds the finished item in its final step, and a new request is
// taken as soon as the controller is idle, even while the previous response
// transaction is still waiting.
module binary_modular_inverse #(
   parameter int WIDTH = 64
) (
   input logic     clock,
   input logic     reset,
   bmi_req_if.sink   req_chan,
   bmi_rsp_if.source rsp_chan
);
   import bmi_pkg::*;

   // Command and status are the only links between the two halves.
   cmd_type    cmd;
   status_type status;

   // The controller runs a two-state machine: idle waiting for a request, and
   // running, where it chooses one step per cycle from the datapath flags. It
   // finishes only when the response register is free.
   bmi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds u with one extra carry bit, v, both coefficients kept
   // reduced modulo the modulus, the modulus itself and the response register.
   bmi_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .operand    (req_chan.operand),
      .modulus    (req_chan.modulus),
      .status     (status),
      .inverse    (rsp_chan.inverse),
      .rsp_status (rsp_chan.status)
   );

endmodule
